/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/can_mbe_pkg.sv */
// ----------------------------------------------------------------------------
// CAN message buffer engine package
// Request and result codes, the stored frame layout and small helpers.
// ----------------------------------------------------------------------------
package can_mbe_pkg;

	localparam int ID_W      = 16;
	localparam int SIZE_W    = 4;
	localparam int DATA_W    = 64;
	localparam int IDT_W     = 32;
	localparam int SHIFT_EXT = 3;
	localparam int SHIFT_STD = 21;
	localparam logic [SIZE_W-1:0] MAX_SIZE = 4'd8;

	typedef enum logic [1:0] {
		REQ_HOST_TX  = 2'd0,
		REQ_HOST_RX  = 2'd1,
		REQ_FRAME_RX = 2'd2,
		REQ_TX_DONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		RES_NONE      = 2'd0,
		RES_SENT      = 2'd1,
		RES_DELIVERED = 2'd2,
		RES_STORED    = 2'd3
	} result_t;

	// configuration register indexes
	localparam logic [0:0] CFG_ACTIVE_SLOTS = 1'b0;
	localparam logic [0:0] CFG_EXTENDED_IDS = 1'b1;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic [SIZE_W-1:0] size;
		logic [ID_W-1:0]   id;
	} frame_t;

	localparam int FRAME_W = $bits(frame_t);

	function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] s);
		return (s > MAX_SIZE) ? MAX_SIZE : s;
	endfunction

	// zero every byte at and above size
	function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] d,
	                                                 input logic [SIZE_W-1:0] size);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int b = 0; b < DATA_W / 8; b++) begin
			if (SIZE_W'(b) < size) begin
				m[b*8 +: 8] = 8'hFF;
			end
		end
		return d & m;
	endfunction

	function automatic logic [IDT_W-1:0] make_idt(input logic [ID_W-1:0] id, input logic ext);
		logic [IDT_W-1:0] w;
		w = {{(IDT_W-ID_W){1'b0}}, id};
		return ext ? (w << SHIFT_EXT) : (w << SHIFT_STD);
	endfunction

	function automatic logic [ID_W-1:0] idt_to_id(input logic [IDT_W-1:0] idt, input logic ext);
		logic [IDT_W-1:0] w;
		w = ext ? (idt >> SHIFT_EXT) : (idt >> SHIFT_STD);
		return w[ID_W-1:0];
	endfunction

endpackage

/* rtl/can_mbe_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with read enable and registered read data.
// ----------------------------------------------------------------------------
module can_mbe_ram #(
	parameter int WIDTH = 84,
	parameter int DEPTH = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/can_message_buffer_engine_unit.sv */
// ----------------------------------------------------------------------------
// CAN message buffer engine
// Transmit mailbox/ring and receive slots between a CAN controller and a host.
// ----------------------------------------------------------------------------
// Each request beat is accepted in ST_IDLE, which issues the reads of the
// receive slot memory (lowest flagged slot in use) and the transmit ring memory
// (oldest entry), and is finished in ST_EXEC, which uses the registered read
// data, writes back a stored frame, updates flags and ring indexes and loads
// the result register. One request is in flight at a time; the result register
// lets a new request be accepted while the previous result waits, and ST_EXEC
// holds while that result is still not taken. Neither memory needs a clearing
// pass: slots are read only after being flagged and ring entries only after
// being written. Result beats carry result_kind on tuser; msg_available
// reflects the receive flags after the request.
`include "assert_macros.svh"

module can_message_buffer_engine_unit
	import can_mbe_pkg::*;
#(
	parameter int RX_SLOTS = 14,
	parameter int TX_DEPTH = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	// request: tdata = mob_busy, in_id, in_size, in_data, in_slot, rx_idt, zero pad
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,
	// tuser = req_type
	input  logic [1:0]   s_axis_tuser,
	// result: tdata = out_id, out_size, out_data, out_idt, out_ext, msg_available, zero pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [119:0] m_axis_tdata,
	// tuser = result_kind
	output logic [1:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [3:0]   cfg_data
);

	localparam int SLOT_W = (RX_SLOTS > 1) ? $clog2(RX_SLOTS) : 1;
	localparam int TX_W   = $clog2(TX_DEPTH);

	typedef enum logic {ST_IDLE, ST_EXEC} state_t;

	state_t            state_q;
	logic [3:0]        active_slots_q;
	logic              extended_ids_q;
	logic [RX_SLOTS-1:0] flags_q;
	logic [TX_W-1:0]   wr_idx_q;
	logic [TX_W-1:0]   rd_idx_q;

	// request held for ST_EXEC
	req_t              req_q;
	logic              busy_q;
	frame_t            frame_q;
	logic              slot_ok_q;
	logic [SLOT_W-1:0] slot_q;
	logic              rx_hit_q;
	logic [SLOT_W-1:0] rx_sel_q;
	logic              tx_avail_q;

	// result register
	logic              m_valid_q;
	result_t           m_kind_q;
	frame_t            m_frame_q;
	logic [IDT_W-1:0]  m_idt_q;
	logic              m_ext_q;
	logic              m_avail_q;

	// request fields
	req_t              in_req;
	logic              in_busy;
	logic [ID_W-1:0]   in_id;
	logic [SIZE_W-1:0] in_size;
	logic [DATA_W-1:0] in_data;
	logic [3:0]        in_slot;
	logic [IDT_W-1:0]  in_idt;
	logic [SIZE_W-1:0] in_size_sat;

	logic              accept;
	logic              commit;
	logic [4:0]        n_use;
	logic              rx_hit;
	logic [SLOT_W-1:0] rx_sel;
	logic              slot_ok;

	frame_t            rx_rdata;
	frame_t            tx_rdata;
	logic              rx_we;
	logic              tx_we;

	result_t           res_kind;
	frame_t            res_frame;
	logic [IDT_W-1:0]  res_idt;
	logic              res_ext;
	logic [RX_SLOTS-1:0] flags_next;

	assign in_req  = req_t'(s_axis_tuser);
	assign in_busy = s_axis_tdata[0];
	assign in_id   = s_axis_tdata[16:1];
	assign in_size = s_axis_tdata[20:17];
	assign in_data = s_axis_tdata[84:21];
	assign in_slot = s_axis_tdata[88:85];
	assign in_idt  = s_axis_tdata[120:89];
	assign in_size_sat = sat_size(in_size);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign commit = (state_q == ST_EXEC) && (!m_valid_q || m_axis_tready);

	// slots in use: min(active_slots, RX_SLOTS)
	assign n_use = ({1'b0, active_slots_q} > 5'(RX_SLOTS)) ? 5'(RX_SLOTS)
	                                                       : {1'b0, active_slots_q};
	assign slot_ok = ({1'b0, in_slot} < n_use);

	// lowest flagged slot in use
	always_comb begin
		rx_hit = 1'b0;
		rx_sel = '0;
		for (int i = RX_SLOTS - 1; i >= 0; i--) begin
			if (flags_q[i] && (5'(i) < n_use)) begin
				rx_hit = 1'b1;
				rx_sel = SLOT_W'(i);
			end
		end
	end

	function automatic logic [TX_W-1:0] next_idx(input logic [TX_W-1:0] i);
		return (i == TX_W'(TX_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign rx_we = commit && (req_q == REQ_FRAME_RX) && slot_ok_q;
	assign tx_we = commit && (req_q == REQ_HOST_TX) && busy_q;

	can_mbe_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (RX_SLOTS),
		.ADDR_W(SLOT_W)
	) u_rx_ram (
		.clk  (clk),
		.we   (rx_we),
		.waddr(slot_q),
		.wdata(frame_q),
		.re   (accept),
		.raddr(rx_sel),
		.rdata(rx_rdata)
	);

	can_mbe_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (TX_DEPTH),
		.ADDR_W(TX_W)
	) u_tx_ram (
		.clk  (clk),
		.we   (tx_we),
		.waddr(wr_idx_q),
		.wdata(frame_q),
		.re   (accept),
		.raddr(rd_idx_q),
		.rdata(tx_rdata)
	);

	// result and flag update for the request in ST_EXEC
	always_comb begin
		res_kind   = RES_NONE;
		res_frame  = '0;
		res_idt    = '0;
		res_ext    = 1'b0;
		flags_next = flags_q;
		case (req_q)
			REQ_HOST_TX: begin
				if (busy_q) begin
					res_kind = RES_STORED;
				end else begin
					res_kind  = RES_SENT;
					res_frame = frame_q;
					res_idt   = make_idt(frame_q.id, extended_ids_q);
					res_ext   = extended_ids_q;
				end
			end
			REQ_HOST_RX: begin
				if (rx_hit_q) begin
					res_kind   = RES_DELIVERED;
					res_frame  = rx_rdata;
					flags_next[rx_sel_q] = 1'b0;
				end
			end
			REQ_FRAME_RX: begin
				if (slot_ok_q) begin
					res_kind = RES_STORED;
					flags_next[slot_q] = 1'b1;
				end
			end
			REQ_TX_DONE: begin
				if (tx_avail_q) begin
					res_kind  = RES_SENT;
					res_frame = tx_rdata;
					res_idt   = make_idt(tx_rdata.id, extended_ids_q);
					res_ext   = extended_ids_q;
				end
			end
			default: begin
				res_kind = RES_NONE;
			end
		endcase
	end

	// hold the request for ST_EXEC
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q        <= in_req;
			busy_q       <= in_busy;
			frame_q.id   <= (in_req == REQ_FRAME_RX) ? idt_to_id(in_idt, extended_ids_q) : in_id;
			frame_q.size <= in_size_sat;
			frame_q.data <= keep_bytes(in_data, in_size_sat);
			slot_ok_q    <= slot_ok;
			slot_q       <= in_slot[SLOT_W-1:0];
			rx_hit_q     <= rx_hit;
			rx_sel_q     <= rx_sel;
			tx_avail_q   <= (rd_idx_q != wr_idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			active_slots_q <= '0;
			extended_ids_q <= 1'b1;
			flags_q        <= '0;
			wr_idx_q       <= '0;
			rd_idx_q       <= '0;
			m_valid_q      <= 1'b0;
			m_kind_q       <= RES_NONE;
			m_frame_q      <= '0;
			m_idt_q        <= '0;
			m_ext_q        <= 1'b0;
			m_avail_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ACTIVE_SLOTS) begin
					active_slots_q <= cfg_data;
				end else begin
					extended_ids_q <= cfg_data[0];
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// hold while the previous result is still waiting
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit) begin
				flags_q   <= flags_next;
				m_valid_q <= 1'b1;
				m_kind_q  <= res_kind;
				m_frame_q <= res_frame;
				m_idt_q   <= res_idt;
				m_ext_q   <= res_ext;
				m_avail_q <= |flags_next;
				if (tx_we) begin
					wr_idx_q <= next_idx(wr_idx_q);
				end
				if ((req_q == REQ_TX_DONE) && tx_avail_q) begin
					rd_idx_q <= next_idx(rd_idx_q);
				end
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_kind_q;
	assign m_axis_tdata  = {2'b00, m_avail_q, m_ext_q, m_idt_q,
	                        m_frame_q.data, m_frame_q.size, m_frame_q.id};

	`ASSERT_NEXT(a_accept_exec, accept, state_q == ST_EXEC, "request beat did not enter execute")
	`ASSERT_IMP(a_avail_flags, m_valid_q, m_avail_q == (|flags_q), "msg_available out of step with flags")
	`ASSERT_IMP(a_idt_only_sent, m_valid_q && (m_kind_q != RES_SENT), (m_idt_q == '0) && !m_ext_q, "identifier word on a result that sent nothing")

endmodule
